/* rtl/sbe_pkg.sv */
package sbe_pkg;

    localparam int STACK_DEPTH_DEF    = 256;
    localparam int VARIABLE_COUNT_DEF = 64;
    localparam int PROGRAM_SIZE_DEF   = 1024;

    localparam int LEN_W    = 11;
    localparam int DATA_W   = 32;
    localparam int OPCODE_W = 4;
    localparam int STATUS_W = 3;

    typedef enum logic [OPCODE_W-1:0] {
        OP_HALT  = 4'd0,
        OP_PUSH  = 4'd1,
        OP_LOAD  = 4'd2,
        OP_STORE = 4'd3,
        OP_ADD   = 4'd4,
        OP_SUB   = 4'd5,
        OP_MUL   = 4'd6,
        OP_DIV   = 4'd7,
        OP_GT    = 4'd8,
        OP_LT    = 4'd9,
        OP_EQ    = 4'd10,
        OP_JMP   = 4'd11,
        OP_JZ    = 4'd12,
        OP_EMIT  = 4'd13,
        OP_DUP   = 4'd14,
        OP_POP   = 4'd15
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_RUN    = 3'd0,
        ST_HALT   = 3'd1,
        ST_OVF    = 3'd2,
        ST_UNF    = 3'd3,
        ST_BADVAR = 3'd4,
        ST_DIV0   = 3'd5
    } status_t;

    // classified instruction handed from front to back
    typedef struct packed {
        opcode_t            op;
        logic [DATA_W-1:0]  arg;
        logic               var_bad;
    } instr_t;

    localparam int INSTR_W = $bits(instr_t);

endpackage

/* rtl/sbe_front.sv */
module sbe_front #(
    parameter int VARIABLE_COUNT = sbe_pkg::VARIABLE_COUNT_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [39:0]                     s_axis_tdata,
    output logic                            q_valid,
    input  logic                            q_ready,
    output sbe_pkg::instr_t                 q_data
);
    import sbe_pkg::*;

    localparam int QD = 2;

    instr_t     mem_reg [QD];
    logic       wptr_reg, rptr_reg;
    logic [1:0] cnt_reg;
    instr_t     cls;
    logic       push, pop;

    always_comb
    begin
        cls.op       = opcode_t'(s_axis_tdata[OPCODE_W-1:0]);
        cls.arg      = s_axis_tdata[OPCODE_W +: DATA_W];
        cls.var_bad  = ({32'd0, s_axis_tdata[OPCODE_W +: DATA_W]} >= 64'(VARIABLE_COUNT));
    end

    assign s_axis_tready = (cnt_reg != 2'(QD));
    assign push    = s_axis_tvalid && s_axis_tready;
    assign q_valid = (cnt_reg != 2'd0);
    assign pop     = q_valid && q_ready;
    assign q_data  = mem_reg[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= cls;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= ~wptr_reg;
            end
            if (pop)
            begin
                rptr_reg <= ~rptr_reg;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

/* rtl/sbe_divider.sv */
module sbe_divider (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic        done,
    output logic [31:0] q
);
    import sbe_pkg::*;

    logic [31:0] rem_reg, quo_reg, den_reg;
    logic [5:0]  cnt_reg;
    logic        neg_reg, busy_reg, done_reg;
    logic [32:0] trial;
    logic [31:0] shrem;

    assign shrem = {rem_reg[30:0], quo_reg[31]};
    assign trial = {1'b0, shrem} - {1'b0, den_reg};

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= a[31] ? (32'd0 - a) : a;
            den_reg <= b[31] ? (32'd0 - b) : b;
            neg_reg <= a[31] ^ b[31];
        end
        else if (busy_reg)
        begin
            rem_reg <= trial[32] ? shrem : trial[31:0];
            quo_reg <= {quo_reg[30:0], ~trial[32]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd31)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign q    = neg_reg ? (32'd0 - quo_reg) : quo_reg;

endmodule

/* rtl/sbe_back.sv */
module sbe_back #(
    parameter int STACK_DEPTH    = sbe_pkg::STACK_DEPTH_DEF,
    parameter int VARIABLE_COUNT = sbe_pkg::VARIABLE_COUNT_DEF,
    parameter int PROGRAM_SIZE   = sbe_pkg::PROGRAM_SIZE_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [sbe_pkg::LEN_W-1:0] program_length,
    input  logic                     q_valid,
    output logic                     q_ready,
    input  sbe_pkg::instr_t          q_data,
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    output logic [47:0]              m_axis_tdata
);
    import sbe_pkg::*;

    localparam int SP_W = $clog2(STACK_DEPTH + 1);
    localparam int SA_W = $clog2(STACK_DEPTH);
    localparam int VA_W = (VARIABLE_COUNT > 1) ? $clog2(VARIABLE_COUNT) : 1;

    typedef enum logic [2:0] {S_IDLE, S_READ, S_EXEC, S_DIV, S_OUT} state_t;

    state_t            state_reg;
    instr_t            ins_reg;
    logic [SP_W-1:0]   sp_reg;
    logic [LEN_W-1:0]  pc_reg;
    status_t           st_reg;
    logic [DATA_W-1:0] stk [STACK_DEPTH];
    logic [DATA_W-1:0] vars [VARIABLE_COUNT];
    logic [VARIABLE_COUNT-1:0] vvalid_reg;
    logic [DATA_W-1:0] top_reg, sec_reg, var_rd_reg;
    logic              var_ok_reg;
    logic [LEN_W-1:0]  out_pc_reg;
    logic              out_pv_reg;
    logic [DATA_W-1:0] out_val_reg;
    status_t           out_st_reg;

    logic [LEN_W-1:0]  len;
    logic [SA_W-1:0]   a1, a2, wa;
    logic              div_start, div_done;
    logic [DATA_W-1:0] div_q;
    logic [VA_W-1:0]   vidx;

    assign len  = ({21'd0, program_length} < 32'(PROGRAM_SIZE))
                ? program_length : LEN_W'(PROGRAM_SIZE);
    assign a1   = SA_W'(sp_reg - SP_W'(1));
    assign a2   = SA_W'(sp_reg - SP_W'(2));
    assign wa   = SA_W'(sp_reg);
    assign vidx = VA_W'(ins_reg.arg);

    assign q_ready       = (state_reg == S_IDLE);
    assign m_axis_tvalid = (state_reg == S_OUT);
    assign m_axis_tdata  = {1'b0, out_st_reg, out_val_reg, out_pv_reg, out_pc_reg};

    assign div_start = (state_reg == S_EXEC) && (st_reg == ST_RUN) && (pc_reg < len)
                    && (ins_reg.op == OP_DIV) && (sp_reg >= SP_W'(2)) && (top_reg != '0);

    sbe_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .a     (sec_reg),
        .b     (top_reg),
        .done  (div_done),
        .q     (div_q)
    );

    // stack and variable reads in S_READ
    always_ff @(posedge clk)
    begin
        if (state_reg == S_READ)
        begin
            top_reg    <= stk[a1];
            sec_reg    <= stk[a2];
            var_rd_reg <= vars[vidx];
            var_ok_reg <= vvalid_reg[vidx];
        end
    end

    // execution writes
    logic              st_we, var_we;
    logic [SA_W-1:0]   st_wa;
    logic [DATA_W-1:0] st_wd;
    logic [SP_W-1:0]   sp_n;
    logic [LEN_W-1:0]  pc_n;
    status_t           err;
    logic              jumped, pv;
    logic [DATA_W-1:0] pval, alu;
    logic              finish;

    always_comb
    begin
        st_we  = 1'b0;
        var_we = 1'b0;
        st_wa  = wa;
        st_wd  = ins_reg.arg;
        sp_n   = sp_reg;
        err    = ST_RUN;
        jumped = 1'b0;
        pv     = 1'b0;
        pval   = '0;
        alu    = '0;
        finish = 1'b1;
        unique case (ins_reg.op)
            OP_ADD: alu = sec_reg + top_reg;
            OP_SUB: alu = sec_reg - top_reg;
            OP_MUL: alu = sec_reg * top_reg;
            OP_DIV: alu = div_q;
            OP_GT:  alu = DATA_W'($signed(sec_reg) > $signed(top_reg));
            OP_LT:  alu = DATA_W'($signed(sec_reg) < $signed(top_reg));
            OP_EQ:  alu = DATA_W'(sec_reg == top_reg);
            default: alu = '0;
        endcase
        unique case (ins_reg.op)
            OP_HALT: ;
            OP_PUSH, OP_LOAD:
            begin
                if (ins_reg.op == OP_LOAD && ins_reg.var_bad) err = ST_BADVAR;
                else if (sp_reg >= SP_W'(STACK_DEPTH)) err = ST_OVF;
                else
                begin
                    st_we = 1'b1;
                    st_wd = (ins_reg.op == OP_PUSH) ? ins_reg.arg
                          : (var_ok_reg ? var_rd_reg : '0);
                    sp_n  = sp_reg + SP_W'(1);
                end
            end
            OP_STORE:
            begin
                if (ins_reg.var_bad) err = ST_BADVAR;
                else if (sp_reg == '0) err = ST_UNF;
                else
                begin
                    var_we = 1'b1;
                    sp_n   = sp_reg - SP_W'(1);
                end
            end
            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_GT, OP_LT, OP_EQ:
            begin
                if (sp_reg < SP_W'(2)) err = ST_UNF;
                else if (ins_reg.op == OP_DIV && top_reg == '0) err = ST_DIV0;
                else
                begin
                    st_we = 1'b1;
                    st_wa = a2;
                    st_wd = alu;
                    sp_n  = sp_reg - SP_W'(1);
                    if (ins_reg.op == OP_DIV && state_reg != S_DIV) finish = 1'b0;
                end
            end
            OP_JMP: jumped = 1'b1;
            OP_JZ:
            begin
                if (sp_reg == '0) err = ST_UNF;
                else
                begin
                    sp_n   = sp_reg - SP_W'(1);
                    jumped = (top_reg == '0);
                end
            end
            OP_EMIT:
            begin
                if (sp_reg == '0) err = ST_UNF;
                else
                begin
                    sp_n = sp_reg - SP_W'(1);
                    pv   = 1'b1;
                    pval = top_reg;
                end
            end
            OP_DUP:
            begin
                if (sp_reg == '0) err = ST_UNF;
                else if (sp_reg >= SP_W'(STACK_DEPTH)) err = ST_OVF;
                else
                begin
                    st_we = 1'b1;
                    st_wd = top_reg;
                    sp_n  = sp_reg + SP_W'(1);
                end
            end
            OP_POP:
            begin
                if (sp_reg == '0) err = ST_UNF;
                else sp_n = sp_reg - SP_W'(1);
            end
            default: ;
        endcase
        pc_n = pc_reg + LEN_W'(1);
        if (jumped)
        begin
            pc_n = (ins_reg.arg >= {21'd0, len}) ? len : LEN_W'(ins_reg.arg);
        end
    end

    logic commit;
    assign commit = ((state_reg == S_EXEC && finish) || (state_reg == S_DIV && div_done))
                 && st_reg == ST_RUN && pc_reg < len && err == ST_RUN;

    always_ff @(posedge clk)
    begin
        if (commit && st_we)
        begin
            stk[st_wa] <= st_wd;
        end
        if (commit && var_we)
        begin
            vars[vidx] <= top_reg;
        end
        if (state_reg == S_IDLE && q_valid)
        begin
            ins_reg <= q_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            sp_reg      <= '0;
            pc_reg      <= '0;
            st_reg      <= ST_RUN;
            vvalid_reg  <= '0;
            out_pc_reg  <= '0;
            out_pv_reg  <= 1'b0;
            out_val_reg <= '0;
            out_st_reg  <= ST_RUN;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (q_valid) state_reg <= S_READ;
                end
                S_READ: state_reg <= S_EXEC;
                S_EXEC, S_DIV:
                begin
                    if (state_reg == S_EXEC && !finish && st_reg == ST_RUN && pc_reg < len
                        && err == ST_RUN)
                    begin
                        state_reg <= S_DIV;
                    end
                    else if (state_reg == S_EXEC || div_done)
                    begin
                        state_reg   <= S_OUT;
                        out_pv_reg  <= 1'b0;
                        out_val_reg <= '0;
                        out_pc_reg  <= pc_reg;
                        out_st_reg  <= st_reg;
                        if (st_reg == ST_RUN && pc_reg >= len)
                        begin
                            st_reg     <= ST_HALT;
                            out_st_reg <= ST_HALT;
                        end
                        else if (st_reg == ST_RUN && err != ST_RUN)
                        begin
                            st_reg     <= err;
                            out_st_reg <= err;
                        end
                        else if (st_reg == ST_RUN)
                        begin
                            sp_reg      <= sp_n;
                            pc_reg      <= pc_n;
                            out_pc_reg  <= pc_n;
                            out_pv_reg  <= pv;
                            out_val_reg <= pval;
                            if (var_we) vvalid_reg[vidx] <= 1'b1;
                            if (ins_reg.op == OP_HALT || pc_n >= len)
                            begin
                                st_reg     <= ST_HALT;
                                out_st_reg <= ST_HALT;
                            end
                        end
                    end
                end
                S_OUT:
                begin
                    if (m_axis_tready) state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

/* rtl/stack_bytecode_executor.sv */
// channel     dir  signals                       beat
// s_axis      in   tvalid tready tdata[39:0]     opcode[3:0], operand[35:4]
// m_axis      out  tvalid tready tdata[47:0]     next_pc[10:0], print_valid[11],
//                                                print_value[43:12], status[46:44]
// cfg         in   cfg_we cfg_wdata[10:0]        program_length
// an instruction passes through the back end as queue pop, stack memory read,
// execute and write, result beat
// div also waits in S_DIV on the iterative divider
// the two-entry queue keeps taking beats until full while a result waits on m_axis
// rst_n clears stack pointer, pc, status, variable valid bits and program_length
module stack_bytecode_executor #(
    parameter int STACK_DEPTH    = sbe_pkg::STACK_DEPTH_DEF,
    parameter int VARIABLE_COUNT = sbe_pkg::VARIABLE_COUNT_DEF,
    parameter int PROGRAM_SIZE   = sbe_pkg::PROGRAM_SIZE_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [sbe_pkg::LEN_W-1:0] cfg_wdata,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    input  logic [39:0]              s_axis_tdata,   // opcode, operand
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    output logic [47:0]              m_axis_tdata    // next_pc, print_valid, print_value, status
);
    import sbe_pkg::*;

    logic [LEN_W-1:0] len_reg;
    logic             q_valid, q_ready;
    instr_t           q_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
        end
        else if (cfg_we)
        begin
            len_reg <= cfg_wdata;
        end
    end

    sbe_front #(.VARIABLE_COUNT(VARIABLE_COUNT)) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .q_valid       (q_valid),
        .q_ready       (q_ready),
        .q_data        (q_data)
    );

    sbe_back #(
        .STACK_DEPTH    (STACK_DEPTH),
        .VARIABLE_COUNT (VARIABLE_COUNT),
        .PROGRAM_SIZE   (PROGRAM_SIZE)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .program_length (len_reg),
        .q_valid        (q_valid),
        .q_ready        (q_ready),
        .q_data         (q_data),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata)
    );

endmodule

/* bench/tb.sv */
module tb;
    import sbe_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [10:0] next_pc;
        logic        print_valid;
        logic [31:0] print_value;
        status_t     status;
    } result_t;

    typedef struct {
        opcode_t     op;
        logic [31:0] arg;
        bit          typed;
        logic [10:0] next_pc;
        logic [31:0] print_value;
        status_t     status;
    } row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [10:0] cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;   // opcode, operand
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;        // next_pc, print_valid, print_value, status

    stack_bytecode_executor i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #6 clk = ~clk;

    // machine state as the block should hold it
    logic [31:0] stack_mem [256];
    logic [31:0] var_mem [64];
    int          sp;
    int          pc;
    status_t     run_st;
    int          prog_len;
    result_t     pending_results [$];

    int  mismatches;
    int  idle_cycles;
    bit  calm;
    bit  beat_seen;

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    function automatic int eff_len();
        return prog_len > 1024 ? 1024 : prog_len;
    endfunction

    function automatic logic [31:0] sdiv(logic [31:0] a, logic [31:0] b);
        logic [31:0] ma;
        logic [31:0] mb;
        logic [31:0] q;
        ma = a[31] ? -a : a;
        mb = b[31] ? -b : b;
        q  = ma / mb;
        return (a[31] ^ b[31]) ? -q : q;
    endfunction

    task automatic run_instruction(opcode_t op, logic [31:0] arg);
        result_t     r;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] v;
        int          nsp;
        int          npc;
        status_t     err;
        bit          jumped;
        r.print_valid = 1'b0;
        r.print_value = '0;
        nsp    = sp;
        npc    = pc + 1;
        err    = ST_RUN;
        jumped = 1'b0;
        if (run_st == ST_RUN && pc >= eff_len()) begin
            run_st = ST_HALT;
        end
        else if (run_st == ST_RUN) begin
            case (op)
                OP_HALT: run_st = ST_HALT;
                OP_PUSH, OP_LOAD:
                begin
                    if (op == OP_LOAD && arg >= 64) err = ST_BADVAR;
                    else if (nsp >= 256) err = ST_OVF;
                    else
                    begin
                        stack_mem[nsp] = (op == OP_PUSH) ? arg : var_mem[arg[5:0]];
                        nsp++;
                    end
                end
                OP_STORE:
                begin
                    if (arg >= 64) err = ST_BADVAR;
                    else if (nsp == 0) err = ST_UNF;
                    else
                    begin
                        nsp--;
                        var_mem[arg[5:0]] = stack_mem[nsp];
                    end
                end
                OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_GT, OP_LT, OP_EQ:
                begin
                    if (nsp < 2) err = ST_UNF;
                    else
                    begin
                        b = stack_mem[nsp - 1];
                        a = stack_mem[nsp - 2];
                        v = '0;
                        case (op)
                            OP_ADD: v = a + b;
                            OP_SUB: v = a - b;
                            OP_MUL: v = a * b;
                            OP_DIV:
                            begin
                                if (b == 0) err = ST_DIV0;
                                else v = sdiv(a, b);
                            end
                            OP_GT: v = ($signed(a) > $signed(b)) ? 32'd1 : 32'd0;
                            OP_LT: v = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
                            default: v = (a == b) ? 32'd1 : 32'd0;
                        endcase
                        if (err == ST_RUN)
                        begin
                            stack_mem[nsp - 2] = v;
                            nsp--;
                        end
                    end
                end
                OP_JMP: jumped = 1'b1;
                OP_JZ:
                begin
                    if (nsp == 0) err = ST_UNF;
                    else
                    begin
                        nsp--;
                        if (stack_mem[nsp] == 0) jumped = 1'b1;
                    end
                end
                OP_EMIT:
                begin
                    if (nsp == 0) err = ST_UNF;
                    else
                    begin
                        nsp--;
                        r.print_value = stack_mem[nsp];
                        r.print_valid = 1'b1;
                    end
                end
                OP_DUP:
                begin
                    if (nsp == 0) err = ST_UNF;
                    else if (nsp >= 256) err = ST_OVF;
                    else
                    begin
                        stack_mem[nsp] = stack_mem[nsp - 1];
                        nsp++;
                    end
                end
                default:
                begin
                    if (nsp == 0) err = ST_UNF;
                    else nsp--;
                end
            endcase
            if (err != ST_RUN) run_st = err;
            else
            begin
                if (jumped) npc = (arg >= eff_len()) ? eff_len() : int'(arg);
                sp = nsp;
                pc = npc;
                if (run_st == ST_RUN && pc >= eff_len()) run_st = ST_HALT;
            end
        end
        if (err != ST_RUN) r.print_valid = 1'b0;
        if (!r.print_valid) r.print_value = '0;
        r.next_pc = pc[10:0];
        r.status  = run_st;
        pending_results.push_back(r);
    endtask

    task automatic send_instr(opcode_t op, logic [31:0] arg);
        bit go;
        while (!calm && $urandom_range(0, 99) < 23)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0000, arg, op};
        do
        begin
            @(negedge clk);
            go = s_axis_tready;
            @(posedge clk);
        end while (!go);
        run_instruction(op, arg);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_len(int value);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= value[10:0];
        @(posedge clk);
        cfg_we    <= 1'b0;
        prog_len = value;
    endtask

    // legal instruction picked from the current state so the program keeps running
    task automatic send_random();
        opcode_t     op;
        logic [31:0] arg;
        bit          ok;
        do
        begin
            op  = opcode_t'($urandom_range(1, 15));
            arg = $urandom;
            case (op)
                OP_PUSH:  ok = sp < 200;
                OP_LOAD:  ok = sp < 200;
                OP_STORE, OP_JZ, OP_EMIT, OP_POP: ok = sp >= 1;
                OP_DUP:   ok = sp >= 1 && sp < 200;
                OP_DIV:   ok = sp >= 2 && stack_mem[sp - 1] != 0;
                OP_JMP:   ok = $urandom_range(0, 3) == 0;
                default:  ok = sp >= 2;
            endcase
        end while (!ok);
        if (pc + 1 >= eff_len()) op = OP_JMP;
        case (op)
            OP_PUSH:
            begin
                case ($urandom_range(0, 7))
                    0: arg = 32'h8000_0000;
                    1: arg = 32'h7fff_ffff;
                    2: arg = 32'hffff_ffff;
                    3: arg = $urandom_range(0, 3);
                    default: ;
                endcase
            end
            OP_LOAD, OP_STORE: arg = $urandom_range(0, 63);
            OP_JMP, OP_JZ: arg = $urandom_range(0, eff_len() - 1);
            default: ;
        endcase
        send_instr(op, arg);
    endtask

    task automatic send_ending();
        int pick;
        pick = $urandom_range(0, 7);
        case (pick)
            0: write_len(0);
            1: send_instr(OP_HALT, $urandom);
            2: send_instr(OP_JMP, $urandom_range(0, 1) ? (32'h8000_0000 | $urandom)
                                                       : eff_len() + $urandom_range(0, 8));
            3: send_instr($urandom_range(0, 1) ? OP_LOAD : OP_STORE,
                          $urandom_range(0, 1) ? $urandom_range(64, 200) : $urandom | 64);
            4:
            begin
                while (sp > 0 && run_st == ST_RUN) send_instr(OP_POP, $urandom);
                send_instr(opcode_t'($urandom_range(0, 1) ? OP_POP : OP_ADD), $urandom);
            end
            5:
            begin
                send_instr(OP_PUSH, $urandom);
                send_instr(OP_PUSH, 32'h0);
                send_instr(OP_DIV, $urandom);
            end
            6:
            begin
                while (sp < 256 && run_st == ST_RUN) send_instr(OP_PUSH, $urandom);
                send_instr($urandom_range(0, 1) ? OP_PUSH : OP_DUP, $urandom);
            end
            default:
            begin
                while (sp > 0 && run_st == ST_RUN) send_instr(OP_POP, $urandom);
                send_instr(OP_DUP, $urandom);
            end
        endcase
        if (pick == 0) send_instr(opcode_t'($urandom_range(1, 15)), $urandom);
        // stopped block: everything after must be ignored
        repeat (12) send_instr(opcode_t'($urandom_range(0, 15)), $urandom);
    endtask

    row_t rows [] = '{
        '{OP_PUSH,  32'h7fff_ffff, 0, 0, 0, ST_RUN},
        '{OP_PUSH,  32'h0000_0001, 0, 0, 0, ST_RUN},
        '{OP_ADD,   32'hffff_ffff, 0, 0, 0, ST_RUN},
        '{OP_DUP,   32'h0000_0000, 0, 0, 0, ST_RUN},
        '{OP_EMIT,  32'h8000_0000, 1, 5, 32'h8000_0000, ST_RUN},
        '{OP_PUSH,  32'hffff_ffff, 0, 0, 0, ST_RUN},
        '{OP_DIV,   32'h5555_5555, 0, 0, 0, ST_RUN},
        '{OP_DUP,   32'haaaa_aaaa, 0, 0, 0, ST_RUN},
        '{OP_EMIT,  32'h0000_0000, 1, 9, 32'h8000_0000, ST_RUN},
        '{OP_PUSH,  32'h0000_0003, 0, 0, 0, ST_RUN},
        '{OP_MUL,   32'h0000_0000, 0, 0, 0, ST_RUN},
        '{OP_PUSH,  32'hffff_fffb, 0, 0, 0, ST_RUN},
        '{OP_SUB,   32'h0000_0000, 0, 0, 0, ST_RUN},
        '{OP_PUSH,  32'h0000_0002, 0, 0, 0, ST_RUN},
        '{OP_GT,    32'h0000_0000, 0, 0, 0, ST_RUN},
        '{OP_PUSH,  32'h0000_0009, 0, 0, 0, ST_RUN},
        '{OP_LT,    32'h0000_0000, 0, 0, 0, ST_RUN},
        '{OP_DUP,   32'h0000_0000, 0, 0, 0, ST_RUN},
        '{OP_EQ,    32'h0000_0000, 0, 0, 0, ST_RUN},
        '{OP_STORE, 32'h0000_003f, 0, 0, 0, ST_RUN},
        '{OP_LOAD,  32'h0000_003f, 0, 0, 0, ST_RUN},
        '{OP_LOAD,  32'h0000_0000, 0, 0, 0, ST_RUN},
        '{OP_JZ,    32'h0000_0028, 1, 40, 0, ST_RUN},
        '{OP_JMP,   32'h0000_0003, 1, 3, 0, ST_RUN},
        '{OP_POP,   32'h0000_0000, 0, 0, 0, ST_RUN}
    };

    // result checker, sampled mid-cycle ahead of the edge that moves the beat
    always @(negedge clk)
    begin
        result_t got;
        result_t want;
        beat_seen = rst_n && ((s_axis_tvalid && s_axis_tready) ||
                              (m_axis_tvalid && m_axis_tready));
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.next_pc     = m_axis_tdata[10:0];
            got.print_valid = m_axis_tdata[11];
            got.print_value = m_axis_tdata[43:12];
            got.status      = status_t'(m_axis_tdata[46:44]);
            if (pending_results.size() == 0)
                report_mismatch("unexpected beat", 32'(got.next_pc), 32'd0);
            else
            begin
                want = pending_results.pop_front();
                if (got.next_pc !== want.next_pc)
                    report_mismatch("next_pc", 32'(got.next_pc), 32'(want.next_pc));
                if (got.print_valid !== want.print_valid)
                    report_mismatch("print_valid", 32'(got.print_valid),
                                    32'(want.print_valid));
                if (got.print_value !== want.print_value)
                    report_mismatch("print_value", got.print_value, want.print_value);
                if (got.status !== want.status)
                    report_mismatch("status", 32'(got.status), 32'(want.status));
            end
        end
    end

    always @(posedge clk)
    begin
        m_axis_tready <= calm || $urandom_range(0, 99) >= 23;
        if (beat_seen) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        sp = 0;
        pc = 0;
        run_st = ST_RUN;
        prog_len = 0;
        mismatches = 0;
        idle_cycles = 0;
        calm = 1'b0;
        beat_seen = 1'b0;
        foreach (var_mem[i]) var_mem[i] = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_len(2047);
        foreach (rows[i])
        begin
            send_instr(rows[i].op, rows[i].arg);
            if (rows[i].typed)
            begin
                pending_results[$].next_pc = rows[i].next_pc;
                if (rows[i].op == OP_EMIT) pending_results[$].print_value = rows[i].print_value;
                pending_results[$].status = rows[i].status;
            end
        end

        write_len(1024);
        repeat (250) send_random();
        calm = 1'b1;
        repeat (150) send_random();
        calm = 1'b0;
        write_len(pc + $urandom_range(2, 300) > 1024 ? 1024 : pc + $urandom_range(2, 300));
        repeat (300) send_random();
        send_ending();

        drain();
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
